FILE: hw/rtl/masked_fault_latch_with_debounce_unit_macros.svh
// Assertion macros shared by the fault latch RTL.
`ifndef MASKED_FAULT_LATCH_WITH_DEBOUNCE_UNIT_MACROS_SVH
`define MASKED_FAULT_LATCH_WITH_DEBOUNCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MFL_ASSERT_SAME(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("mfl assertion failed");
`define MFL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfl assertion failed");
`define MFL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfl assertion failed");
`else
`define MFL_ASSERT_SAME(lbl, clk, rst, cond)
`define MFL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define MFL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/mfl_pkg.sv
// Types and constants of the masked fault latch with debounce.
package mfl_pkg;

   localparam int FaultWidth    = 16;
   localparam int DebounceWidth = 8;
   localparam int CsrIndexWidth = 2;

   localparam logic [DebounceWidth-1:0] DebounceAllLow  = 8'h00;
   localparam logic [DebounceWidth-1:0] DebounceAllHigh = 8'hFF;

   localparam logic [FaultWidth-1:0] MaskReset     = 16'hFFFF;
   localparam logic [FaultWidth-1:0] NonMaskReset  = 16'h0000;
   localparam logic [FaultWidth-1:0] ExternalReset = 16'h0001;

   typedef enum logic [1:0] {
      OP_TRIGGER  = 2'd0,
      OP_CLEAR    = 2'd1,
      OP_SET_MASK = 2'd2,
      OP_TICK     = 2'd3
   } op_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_NON_MASKABLE = 2'd0,
      CSR_EXTERNAL     = 2'd1
   } csr_index_type;

   typedef struct packed {
      op_type                op;
      logic [FaultWidth-1:0] fault_bits;
      logic                  pin_level;
   } req_type;

   typedef struct packed {
      logic [FaultWidth-1:0] fault_flags;
      logic [FaultWidth-1:0] mask_value;
      logic                  status_fault;
      logic                  disable_load;
      logic                  pin_drive_low;
      logic                  led_on;
   } rsp_type;

   typedef struct packed {
      logic [FaultWidth-1:0]    fault;
      logic [FaultWidth-1:0]    mask;
      logic                     status;
      logic                     drive;
      logic                     led;
      logic [DebounceWidth-1:0] debounce;
      logic                     ext_armed;
   } state_type;

   typedef struct packed {
      logic [FaultWidth-1:0] non_maskable;
      logic [FaultWidth-1:0] external;
   } cfg_type;

endpackage

FILE: hw/rtl/mfl_eval.sv
// Next-state and result logic for one fault latch operation.
module mfl_eval (
   input  mfl_pkg::req_type   item,
   input  mfl_pkg::state_type cur,
   input  mfl_pkg::cfg_type   cfg,
   output mfl_pkg::state_type nxt,
   output mfl_pkg::rsp_type   rsp
);

   logic [mfl_pkg::FaultWidth-1:0]    fault_new;
   logic [mfl_pkg::DebounceWidth-1:0] shift_new;
   logic                              do_eval;
   logic                              unmasked;
   logic                              internal_set;

   always_comb begin
      nxt       = cur;
      fault_new = cur.fault;
      shift_new = {cur.debounce[mfl_pkg::DebounceWidth-2:0], item.pin_level};
      do_eval   = 1'b0;
      case (item.op)
         mfl_pkg::OP_TRIGGER: begin
            fault_new = cur.fault | item.fault_bits;
            do_eval   = (fault_new != cur.fault);
         end
         mfl_pkg::OP_CLEAR: begin
            fault_new = cur.fault & ~item.fault_bits;
            do_eval   = 1'b1;
         end
         mfl_pkg::OP_SET_MASK: begin
            nxt.mask = item.fault_bits | cfg.non_maskable;
            do_eval  = 1'b1;
         end
         mfl_pkg::OP_TICK: begin
            nxt.debounce = shift_new;
            if (shift_new == mfl_pkg::DebounceAllLow) begin
               // The pin fires once per low period, and only with no live fault.
               if (!cur.ext_armed && ((cur.fault & cur.mask) == '0)) begin
                  fault_new     = cur.fault | cfg.external;
                  do_eval       = (fault_new != cur.fault);
                  nxt.ext_armed = 1'b1;
               end
            end else if (shift_new == mfl_pkg::DebounceAllHigh) begin
               nxt.ext_armed = 1'b0;
            end
         end
         default: begin
            do_eval = 1'b0;
         end
      endcase
      nxt.fault = fault_new;

      unmasked     = ((fault_new & nxt.mask) != '0);
      internal_set = ((fault_new & ~cfg.external) != '0);
      if (do_eval) begin
         nxt.status = unmasked;
         nxt.drive  = unmasked && internal_set;
         nxt.led    = unmasked && internal_set;
      end

      rsp.fault_flags   = nxt.fault;
      rsp.mask_value    = nxt.mask;
      rsp.status_fault  = nxt.status;
      rsp.disable_load  = do_eval && unmasked;
      rsp.pin_drive_low = nxt.drive;
      rsp.led_on        = nxt.led;
   end

endmodule

FILE: hw/rtl/mfl_state.sv
// Fault, mask, debounce and configuration registers.
module mfl_state (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                update_en,
   input  mfl_pkg::state_type                  state_in,
   input  logic                                csr_wr_en,
   input  logic [mfl_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [mfl_pkg::FaultWidth-1:0]      csr_wdata,
   output mfl_pkg::state_type                  state_ff,
   output mfl_pkg::cfg_type                    cfg_ff
);

   mfl_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            mfl_pkg::CSR_NON_MASKABLE: cfg_in.non_maskable = csr_wdata;
            mfl_pkg::CSR_EXTERNAL:     cfg_in.external     = csr_wdata;
            default:                   cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.fault     <= '0;
         state_ff.mask      <= mfl_pkg::MaskReset;
         state_ff.status    <= 1'b0;
         state_ff.drive     <= 1'b0;
         state_ff.led       <= 1'b0;
         state_ff.debounce  <= mfl_pkg::DebounceAllHigh;
         state_ff.ext_armed <= 1'b0;
         cfg_ff.non_maskable <= mfl_pkg::NonMaskReset;
         cfg_ff.external     <= mfl_pkg::ExternalReset;
      end else begin
         if (update_en) begin
            state_ff <= state_in;
         end
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/masked_fault_latch_with_debounce_unit.sv
// Top level of the masked fault latch with external pin debounce.
//
//   port group  direction  transfer when         payload
//   req_        in         req_valid & !req_stall  mfl_pkg::req_type
//   rsp_        out        rsp_valid & !rsp_stall  mfl_pkg::rsp_type
//   csr_        in         csr_wr_en              index and 16-bit data
//
// One item per cycle sustained while the result is not stalled; a request passes the
// input register, then evaluation into the result register, before its result is valid.
// The state registers update in the same cycle the result register loads.
// Reset is synchronous; no clearing pass is needed.
// A stalled result holds the input register, which then stalls the request side.
`include "masked_fault_latch_with_debounce_unit_macros.svh"
module masked_fault_latch_with_debounce_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mfl_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mfl_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [mfl_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [mfl_pkg::FaultWidth-1:0]    csr_wdata
);

   logic               s1_valid_ff;
   logic               s1_valid_in;
   mfl_pkg::req_type   s1_item_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   mfl_pkg::rsp_type   rsp_payload_ff;
   mfl_pkg::rsp_type   rsp_payload_in;
   mfl_pkg::state_type state_ff;
   mfl_pkg::state_type state_in;
   mfl_pkg::cfg_type   cfg_ff;
   logic               out_ready;
   logic               advance;
   logic               accept;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   mfl_eval u_eval (
      .item (s1_item_ff),
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .nxt  (state_in),
      .rsp  (rsp_payload_in)
   );

   mfl_state u_state (
      .clock     (clock),
      .reset     (reset),
      .update_en (advance),
      .state_in  (state_in),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .state_ff  (state_ff),
      .cfg_ff    (cfg_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The status bit always tracks whether an unmasked fault is latched.
   `MFL_ASSERT_SAME(a_status_tracks_fault, clock, reset,
      state_ff.status == ((state_ff.fault & state_ff.mask) != '0))
   `MFL_ASSERT_IMPLIES(a_disable_needs_status, clock, reset,
      rsp_valid_ff && rsp_payload_ff.disable_load, rsp_payload_ff.status_fault)
   `MFL_ASSERT_IMPLIES(a_pin_led_agree, clock, reset,
      rsp_valid_ff, rsp_payload_ff.pin_drive_low == rsp_payload_ff.led_on)
   `MFL_ASSERT_NEXT(a_stage_holds, clock, reset,
      s1_valid_ff && !advance, s1_valid_ff && $stable(s1_item_ff))

endmodule
